FILE: rtl/beha_pkg.sv
package beha_pkg;

    // Sizes of the sample and the hold counters.
    localparam int NUM_BUTTONS = 12;
    localparam int BTN_W       = 12;
    localparam int QRY_W       = 4;
    localparam int CNT_W       = 8;
    localparam int DIR_W       = 4;
    localparam int CFG_IDX_W   = 8;
    localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // The remainder unit retires two quotient bits per cycle.
    localparam int REM_CYCLES  = CNT_W / 2;
    localparam int REM_STEP_W  = $clog2(REM_CYCLES);

    localparam logic [CNT_W-1:0] HOLD_MAX      = 8'd255;
    localparam logic [CNT_W-1:0] DELAY_RESET   = 8'd18;
    localparam logic [CNT_W-1:0] RATE_RESET    = 8'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_RATE  = 8'd1;

    // Keypad direction codes.
    localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 4'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN       = 4'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 4'd3;
    localparam logic [DIR_W-1:0] DIR_LEFT       = 4'd4;
    localparam logic [DIR_W-1:0] DIR_NEUTRAL    = 4'd5;
    localparam logic [DIR_W-1:0] DIR_RIGHT      = 4'd6;
    localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 4'd7;
    localparam logic [DIR_W-1:0] DIR_UP         = 4'd8;
    localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 4'd9;

    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic [QRY_W-1:0] query_button;
    } in_word_t;

    typedef struct packed {
        logic [BTN_W-1:0] pressed_mask;
        logic [BTN_W-1:0] released_mask;
        logic [BTN_W-1:0] repeat_mask;
        logic [DIR_W-1:0] direction;
        logic             direction_changed;
        logic [CNT_W-1:0] held_frames;
    } out_word_t;

    // Request to the shared remainder unit.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } rem_req_t;

    // Answer from the shared remainder unit.
    typedef struct packed {
        logic done;
        logic zero;
    } rem_rsp_t;

    // Keypad code from the four direction bits; diagonals win.
    function automatic logic [DIR_W-1:0] keypad_code(input logic [3:0] dirs);
        logic up;
        logic down;
        logic left;
        logic right;
        logic [DIR_W-1:0] code;
        up    = dirs[0];
        down  = dirs[1];
        left  = dirs[2];
        right = dirs[3];
        if (up && left) begin
            code = DIR_UP_LEFT;
        end else if (up && right) begin
            code = DIR_UP_RIGHT;
        end else if (down && left) begin
            code = DIR_DOWN_LEFT;
        end else if (down && right) begin
            code = DIR_DOWN_RIGHT;
        end else if (up) begin
            code = DIR_UP;
        end else if (down) begin
            code = DIR_DOWN;
        end else if (left) begin
            code = DIR_LEFT;
        end else if (right) begin
            code = DIR_RIGHT;
        end else begin
            code = DIR_NEUTRAL;
        end
        return code;
    endfunction

endpackage

FILE: rtl/beha_rem.sv
module beha_rem (
    input  logic                aclk,
    input  logic                aresetn,
    input  beha_pkg::rem_req_t  req,
    output beha_pkg::rem_rsp_t  rsp
);

    logic [beha_pkg::CNT_W-1:0]      rem_reg, rem_next;
    logic [beha_pkg::CNT_W-1:0]      dvd_reg, dvd_next;
    logic [beha_pkg::CNT_W-1:0]      dsr_reg, dsr_next;
    logic [beha_pkg::REM_STEP_W-1:0] step_reg, step_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;

    logic [beha_pkg::CNT_W:0]        trial1;
    logic [beha_pkg::CNT_W:0]        trial2;
    logic [beha_pkg::CNT_W-1:0]      rem_mid;
    logic [beha_pkg::CNT_W-1:0]      rem_step;

    // Two restoring steps per cycle: shift in a dividend bit, subtract if it fits.
    always_comb begin
        trial1 = {rem_reg, dvd_reg[beha_pkg::CNT_W-1]};
        if (trial1 >= {1'b0, dsr_reg}) begin
            trial1 = trial1 - {1'b0, dsr_reg};
        end
        rem_mid = trial1[beha_pkg::CNT_W-1:0];
        trial2  = {rem_mid, dvd_reg[beha_pkg::CNT_W-2]};
        if (trial2 >= {1'b0, dsr_reg}) begin
            trial2 = trial2 - {1'b0, dsr_reg};
        end
        rem_step = trial2[beha_pkg::CNT_W-1:0];
    end

    // Step control.
    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = rem_step;
            dvd_next  = {dvd_reg[beha_pkg::CNT_W-3:0], 2'b00};
            step_next = step_reg + 1'b1;
            if (step_reg == beha_pkg::REM_STEP_W'(beha_pkg::REM_CYCLES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.zero = (rem_reg == '0);

endmodule

FILE: rtl/beha_cnt.sv
module beha_cnt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [beha_pkg::IDX_W-1:0]  addr,
    input  logic                        held,
    input  logic                        upd_en,
    output logic [beha_pkg::CNT_W-1:0]  new_cnt
);

    logic [beha_pkg::CNT_W-1:0] cnt_reg [beha_pkg::NUM_BUTTONS];
    logic [beha_pkg::CNT_W-1:0] cur_cnt;

    // Saturating increment while held, clear on release.
    always_comb begin
        cur_cnt = cnt_reg[addr];
        if (!held) begin
            new_cnt = '0;
        end else if (cur_cnt == beha_pkg::HOLD_MAX) begin
            new_cnt = cur_cnt;
        end else begin
            new_cnt = cur_cnt + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < beha_pkg::NUM_BUTTONS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (upd_en) begin
            cnt_reg[addr] <= new_cnt;
        end
    end

endmodule

FILE: rtl/button_edge_hold_autorepeat_top.sv
// Button sampler: edge detection, hold counting and auto-repeat.
// One input word on s_ is one frame sample of the buttons plus the index
// of the button whose hold count is wanted. One output word on m_ follows
// for each sample: pressed and released masks, the auto-repeat mask, the
// keypad direction with a changed flag, and the queried hold count.
// A small sequencer walks the buttons one per cycle, updating each hold
// counter, and pauses while a rate check runs; a button whose count is
// past the repeat delay, with a rate that is not zero, is checked against
// the rate by a shared remainder unit, which retires two bits a step and
// registers its answer. s_ready is low from acceptance until the result
// enters the output register; the next sample is taken in the cycle after
// that, so a new sample is taken only once the last one has reached the
// output register.
// The output register holds a finished word while m_ready is low; the
// block can take the next sample then, but finishes it only once the
// waiting word has been taken.
// Reset (aresetn low, synchronous) clears the counters and the previous
// sample, sets the previous direction to neutral, and loads the repeat
// delay with 18 and the rate with 4. Configuration writes on cfg_ are
// always taken and belong between samples.
module button_edge_hold_autorepeat_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  beha_pkg::in_word_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output beha_pkg::out_word_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [beha_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [beha_pkg::CNT_W-1:0]        cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                          state_reg, state_next;
    logic [beha_pkg::IDX_W-1:0]          idx_reg, idx_next;
    logic [beha_pkg::BTN_W-1:0]          buttons_reg, buttons_next;
    logic [beha_pkg::QRY_W-1:0]          query_reg, query_next;
    logic [beha_pkg::NUM_BUTTONS-1:0]    repeat_reg, repeat_next;
    logic [beha_pkg::CNT_W-1:0]          held_out_reg, held_out_next;
    logic [beha_pkg::BTN_W-1:0]          prev_buttons_reg, prev_buttons_next;
    logic [beha_pkg::DIR_W-1:0]          prev_dir_reg, prev_dir_next;
    logic [beha_pkg::CNT_W-1:0]          delay_reg, delay_next;
    logic [beha_pkg::CNT_W-1:0]          rate_reg, rate_next;
    logic                                m_valid_reg, m_valid_next;
    beha_pkg::out_word_t                 m_data_reg, m_data_next;

    logic [beha_pkg::NUM_BUTTONS-1:0]    held_vec;
    logic                                cur_held;
    logic                                cnt_upd;
    logic [beha_pkg::CNT_W-1:0]          new_cnt;
    logic                                last_btn;
    logic                                out_load;
    logic [beha_pkg::DIR_W-1:0]          cur_dir;
    beha_pkg::rem_req_t                  rem_req;
    beha_pkg::rem_rsp_t                  rem_rsp;

    // Hold counter bank, one entry updated per scan cycle of the walk, none while a rate check runs.
    beha_cnt u_cnt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .addr    (idx_reg),
        .held    (cur_held),
        .upd_en  (cnt_upd),
        .new_cnt (new_cnt)
    );

    // Shared remainder unit for the repeat-rate check.
    beha_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .rsp     (rem_rsp)
    );

    assign held_vec  = beha_pkg::NUM_BUTTONS'(buttons_reg);
    assign cur_held  = held_vec[idx_reg];
    assign cnt_upd   = (state_reg == ST_SCAN);
    assign last_btn  = (idx_reg == beha_pkg::IDX_W'(beha_pkg::NUM_BUTTONS - 1));
    assign cur_dir   = beha_pkg::keypad_code(buttons_reg[3:0]);
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Configuration registers.
    always_comb begin
        delay_next = delay_reg;
        rate_next  = rate_reg;
        if (cfg_valid) begin
            if (cfg_index == beha_pkg::REG_REPEAT_DELAY) begin
                delay_next = cfg_data;
            end else if (cfg_index == beha_pkg::REG_REPEAT_RATE) begin
                rate_next = cfg_data;
            end
        end
    end

    // Sequencer over the buttons.
    always_comb begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        buttons_next      = buttons_reg;
        query_next        = query_reg;
        repeat_next       = repeat_reg;
        held_out_next     = held_out_reg;
        prev_buttons_next = prev_buttons_reg;
        prev_dir_next     = prev_dir_reg;
        rem_req.start     = 1'b0;
        rem_req.dividend  = new_cnt - delay_reg;
        rem_req.divisor   = rate_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    buttons_next  = s_data.buttons;
                    query_next    = s_data.query_button;
                    repeat_next   = '0;
                    held_out_next = '0;
                    idx_next      = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (query_reg == beha_pkg::QRY_W'(idx_reg)) begin
                    held_out_next = new_cnt;
                end
                if (cur_held && (new_cnt > delay_reg) && (rate_reg != '0)) begin
                    rem_req.start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    if (cur_held && (new_cnt == delay_reg)) begin
                        repeat_next[idx_reg] = 1'b1;
                    end
                    if (last_btn) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (rem_rsp.done) begin
                    if (rem_rsp.zero) begin
                        repeat_next[idx_reg] = 1'b1;
                    end
                    if (last_btn) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    prev_buttons_next = buttons_reg;
                    prev_dir_next     = cur_dir;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next                  = 1'b1;
            m_data_next.pressed_mask      = buttons_reg & ~prev_buttons_reg;
            m_data_next.released_mask     = prev_buttons_reg & ~buttons_reg;
            m_data_next.repeat_mask       = beha_pkg::BTN_W'(repeat_reg);
            m_data_next.direction         = cur_dir;
            m_data_next.direction_changed = (cur_dir != prev_dir_reg);
            m_data_next.held_frames       = held_out_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            prev_buttons_reg <= '0;
            prev_dir_reg     <= beha_pkg::DIR_NEUTRAL;
            delay_reg        <= beha_pkg::DELAY_RESET;
            rate_reg         <= beha_pkg::RATE_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            prev_buttons_reg <= prev_buttons_next;
            prev_dir_reg     <= prev_dir_next;
            delay_reg        <= delay_next;
            rate_reg         <= rate_next;
            m_valid_reg      <= m_valid_next;
        end
        buttons_reg  <= buttons_next;
        query_reg    <= query_next;
        repeat_reg   <= repeat_next;
        held_out_reg <= held_out_next;
        m_data_reg   <= m_data_next;
    end

endmodule

FILE: rtl/beha_chk.sv
module beha_chk (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  beha_pkg::in_word_t                s_data,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  beha_pkg::out_word_t               m_data,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [beha_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [beha_pkg::CNT_W-1:0]        cfg_data
);

    // Reset leaves the block empty and ready for a sample.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("block not empty and ready after reset");

    // The walk over the buttons always outlasts the accepting cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sample taken while a walk was still running");

    // A stalled result word holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result word changed while stalled");

    // A button cannot be both newly pressed and newly released.
    a_edges_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.pressed_mask & m_data.released_mask) == '0))
        else $error("pressed and released masks overlap");

    // A repeating button is held, so it cannot have just been released.
    a_repeat_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.repeat_mask & m_data.released_mask) == '0))
        else $error("repeat reported for a released button");

endmodule

bind button_edge_hold_autorepeat_top beha_chk u_beha_chk (.*);
